FILE: src/ftpc_pkg.sv
// Shared types and constants for the FTP control payload classifier.
`default_nettype none

package ftpc_pkg;

	// Longest tracked payload; the byte counter saturates one below it.
	localparam int MAX_PAYLOAD = 2048;
	localparam int POS_W       = $clog2(MAX_PAYLOAD);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PAYLOAD - 1);

	localparam int NUM_FIELDS     = 6;
	localparam int IDX_W          = 3;
	localparam int NUM_START      = 27;
	localparam int REPLY_MARK_POS = 19;

	// Queue between classifier and parser.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Characters of interest.
	localparam logic [7:0] CH_U      = 8'h55;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_O      = 8'h4F;
	localparam logic [7:0] CH_2      = 8'h32;
	localparam logic [7:0] CH_7      = 8'h37;
	localparam logic [7:0] CH_LOW_E  = 8'h65;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	typedef enum logic [1:0] {
		CAT_PLAIN    = 2'd0,
		CAT_LOGIN    = 2'd1,
		CAT_DOWNLOAD = 2'd2,
		CAT_UPLOAD   = 2'd3
	} category_t;

	typedef enum logic [1:0] {
		TOK_DIGIT = 2'd0,
		TOK_COMMA = 2'd1,
		TOK_CLOSE = 2'd2,
		TOK_OTHER = 2'd3
	} tok_kind_t;

	// One classified byte, handed from the front to the parser.
	typedef struct packed {
		logic      first;     // byte at offset zero: clear parser state
		logic      parse_en;  // offset at or past the number section
		logic      last;      // final byte: a result is due
		tok_kind_t kind;
		logic [3:0] digit;
		category_t cmd_cat;   // command category when matched, else plain
		logic      reply_ok;  // server-to-client reply whose passive header checks all passed
	} token_t;

endpackage

`default_nettype wire

FILE: src/ftpc_front.sv
// Front end: byte offset tracking, header checks and byte classification.
`default_nettype none

module ftpc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              direction,
	input  wire logic              last_byte,
	input  wire logic              q_full,
	output logic                   q_push,
	output ftpc_pkg::token_t       q_tok
);

	logic [ftpc_pkg::POS_W-1:0] pos_q;
	logic [7:0]                 lead_q;
	logic                       prefix_q;
	logic                       down_q;

	logic       pos_first;
	logic [7:0] lead_eff;
	logic       down_eff;
	logic       exp_vld;
	logic [7:0] exp_byte;
	logic       prefix_nxt;
	logic       past_cmd;
	logic       past_mark;

	assign in_ready = ~q_full;
	assign q_push   = in_valid & ~q_full;

	assign pos_first = (pos_q == '0);
	assign lead_eff  = pos_first ? data_byte : lead_q;
	assign down_eff  = pos_first ? direction : down_q;
	assign past_cmd  = (pos_q >= ftpc_pkg::POS_W'(3));
	assign past_mark = (pos_q >= ftpc_pkg::POS_W'(ftpc_pkg::REPLY_MARK_POS));

	// Expected byte at the checked offsets for the latched lead byte
	always_comb begin
		exp_vld  = 1'b0;
		exp_byte = 8'h00;
		case (lead_q)
			ftpc_pkg::CH_U: begin
				exp_vld = (pos_q == ftpc_pkg::POS_W'(1)) || (pos_q == ftpc_pkg::POS_W'(2))
					|| (pos_q == ftpc_pkg::POS_W'(3));
				if (pos_q == ftpc_pkg::POS_W'(1))      exp_byte = ftpc_pkg::CH_S;
				else if (pos_q == ftpc_pkg::POS_W'(2)) exp_byte = ftpc_pkg::CH_E;
				else                                   exp_byte = ftpc_pkg::CH_R;
			end
			ftpc_pkg::CH_R: begin
				exp_vld = (pos_q == ftpc_pkg::POS_W'(1)) || (pos_q == ftpc_pkg::POS_W'(2))
					|| (pos_q == ftpc_pkg::POS_W'(3));
				if (pos_q == ftpc_pkg::POS_W'(1))      exp_byte = ftpc_pkg::CH_E;
				else if (pos_q == ftpc_pkg::POS_W'(2)) exp_byte = ftpc_pkg::CH_T;
				else                                   exp_byte = ftpc_pkg::CH_R;
			end
			ftpc_pkg::CH_S: begin
				exp_vld = (pos_q == ftpc_pkg::POS_W'(1)) || (pos_q == ftpc_pkg::POS_W'(2))
					|| (pos_q == ftpc_pkg::POS_W'(3));
				if (pos_q == ftpc_pkg::POS_W'(1))      exp_byte = ftpc_pkg::CH_T;
				else if (pos_q == ftpc_pkg::POS_W'(2)) exp_byte = ftpc_pkg::CH_O;
				else                                   exp_byte = ftpc_pkg::CH_R;
			end
			ftpc_pkg::CH_2: begin
				exp_vld = (pos_q == ftpc_pkg::POS_W'(1)) || (pos_q == ftpc_pkg::POS_W'(2))
					|| (pos_q == ftpc_pkg::POS_W'(ftpc_pkg::REPLY_MARK_POS));
				if (pos_q == ftpc_pkg::POS_W'(1))      exp_byte = ftpc_pkg::CH_2;
				else if (pos_q == ftpc_pkg::POS_W'(2)) exp_byte = ftpc_pkg::CH_7;
				else                                   exp_byte = ftpc_pkg::CH_LOW_E;
			end
			default: begin
				exp_vld  = 1'b0;
				exp_byte = 8'h00;
			end
		endcase
	end

	assign prefix_nxt = pos_first | (prefix_q & ~(exp_vld & (data_byte != exp_byte)));

	// Token build
	always_comb begin
		q_tok          = '0;
		q_tok.first    = pos_first;
		q_tok.parse_en = (pos_q >= ftpc_pkg::POS_W'(ftpc_pkg::NUM_START));
		q_tok.last     = last_byte;
		q_tok.digit    = data_byte[3:0];
		if (data_byte inside {[ftpc_pkg::CH_0:ftpc_pkg::CH_9]})
			q_tok.kind = ftpc_pkg::TOK_DIGIT;
		else if (data_byte == ftpc_pkg::CH_COMMA)
			q_tok.kind = ftpc_pkg::TOK_COMMA;
		else if (data_byte == ftpc_pkg::CH_RPAREN)
			q_tok.kind = ftpc_pkg::TOK_CLOSE;
		else
			q_tok.kind = ftpc_pkg::TOK_OTHER;
		q_tok.cmd_cat  = ftpc_pkg::CAT_PLAIN;
		if (prefix_nxt && past_cmd) begin
			case (lead_eff)
				ftpc_pkg::CH_U: q_tok.cmd_cat = ftpc_pkg::CAT_LOGIN;
				ftpc_pkg::CH_R: q_tok.cmd_cat = ftpc_pkg::CAT_DOWNLOAD;
				ftpc_pkg::CH_S: q_tok.cmd_cat = ftpc_pkg::CAT_UPLOAD;
				default:        q_tok.cmd_cat = ftpc_pkg::CAT_PLAIN;
			endcase
		end
		q_tok.reply_ok = (lead_eff == ftpc_pkg::CH_2) & down_eff & prefix_nxt & past_mark;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			lead_q   <= 8'h00;
			prefix_q <= 1'b1;
			down_q   <= 1'b0;
		end else if (q_push) begin
			lead_q   <= lead_eff;
			down_q   <= down_eff;
			prefix_q <= prefix_nxt;
			if (last_byte)
				pos_q <= '0;
			else if (pos_q != ftpc_pkg::POS_MAX)
				pos_q <= pos_q + ftpc_pkg::POS_W'(1);
		end
	end

endmodule

`default_nettype wire

FILE: src/ftpc_fifo.sv
// Short token queue between the classifier front and the parser back end.
`default_nettype none

module ftpc_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ftpc_pkg::token_t push_tok,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output ftpc_pkg::token_t      pop_tok
);

	ftpc_pkg::token_t mem_q [ftpc_pkg::FIFO_DEPTH];
	logic [ftpc_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [ftpc_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [ftpc_pkg::FIFO_AW:0]   count_q;

	assign full      = (count_q == (ftpc_pkg::FIFO_AW+1)'(ftpc_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_tok   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + ftpc_pkg::FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + ftpc_pkg::FIFO_AW'(1);
			if (push && !pop)
				count_q <= count_q + (ftpc_pkg::FIFO_AW+1)'(1);
			else if (!push && pop)
				count_q <= count_q - (ftpc_pkg::FIFO_AW+1)'(1);
		end
	end

endmodule

`default_nettype wire

FILE: src/ftpc_back.sv
// Back end: number-list parser and result register.
`default_nettype none

module ftpc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_not_empty,
	input  wire ftpc_pkg::token_t q_tok,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            category,
	output logic                  address_found,
	output logic [31:0]           server_ip,
	output logic [15:0]           server_port
);

	typedef enum logic [1:0] {
		PS_PARSING = 2'd0,
		PS_OK      = 2'd1,
		PS_FAIL    = 2'd2
	} pstat_t;

	// Only the low bits each number contributes to the address are kept;
	// mod-2^32 accumulation makes low bits depend on low bits alone.
	pstat_t                     stat_q, stat_d;
	logic [ftpc_pkg::IDX_W-1:0] idx_q, idx_d;
	logic [31:0]                acc_q, acc_d;
	logic [7:0]                 n0_q, n0_d;
	logic [15:0]                n1_q, n1_d;
	logic [23:0]                n2_q, n2_d;
	logic [31:0]                n3_q, n3_d;
	logic [7:0]                 n4_q, n4_d;
	logic                       out_free;
	logic                       hit;

	assign out_free = ~out_valid | out_ready;
	assign q_pop    = q_not_empty & (~q_tok.last | out_free);

	always_comb begin
		stat_d = stat_q;
		idx_d  = idx_q;
		acc_d  = acc_q;
		n0_d   = n0_q;
		n1_d   = n1_q;
		n2_d   = n2_q;
		n3_d   = n3_q;
		n4_d   = n4_q;
		if (q_tok.first) begin
			stat_d = PS_PARSING;
			idx_d  = '0;
			acc_d  = '0;
			n0_d   = '0;
			n1_d   = '0;
			n2_d   = '0;
			n3_d   = '0;
			n4_d   = '0;
		end else if (q_tok.parse_en && stat_q == PS_PARSING
			&& idx_q < ftpc_pkg::IDX_W'(ftpc_pkg::NUM_FIELDS)) begin
			case (q_tok.kind)
				ftpc_pkg::TOK_DIGIT: begin
					acc_d = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, q_tok.digit};
				end
				ftpc_pkg::TOK_COMMA: begin
					case (idx_q)
						3'd0:    n0_d = acc_q[7:0];
						3'd1:    n1_d = acc_q[15:0];
						3'd2:    n2_d = acc_q[23:0];
						3'd3:    n3_d = acc_q;
						3'd4:    n4_d = acc_q[7:0];
						default: n4_d = n4_q;
					endcase
					acc_d = '0;
					idx_d = idx_q + ftpc_pkg::IDX_W'(1);
					if (idx_q == ftpc_pkg::IDX_W'(ftpc_pkg::NUM_FIELDS - 1))
						stat_d = PS_FAIL;
				end
				ftpc_pkg::TOK_CLOSE: begin
					if (idx_q == ftpc_pkg::IDX_W'(ftpc_pkg::NUM_FIELDS - 1))
						stat_d = PS_OK;
					else
						stat_d = PS_FAIL;
				end
				default: stat_d = PS_FAIL;
			endcase
		end
	end

	assign hit = q_tok.reply_ok & (stat_d == PS_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q    <= PS_PARSING;
			idx_q     <= '0;
			acc_q     <= '0;
			n0_q      <= '0;
			n1_q      <= '0;
			n2_q      <= '0;
			n3_q      <= '0;
			n4_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (q_pop) begin
				stat_q <= stat_d;
				idx_q  <= idx_d;
				acc_q  <= acc_d;
				n0_q   <= n0_d;
				n1_q   <= n1_d;
				n2_q   <= n2_d;
				n3_q   <= n3_d;
				n4_q   <= n4_d;
			end
			if (q_pop && q_tok.last)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (q_pop && q_tok.last) begin
			if (hit) begin
				category      <= ftpc_pkg::CAT_DOWNLOAD;
				address_found <= 1'b1;
				server_ip     <= {n0_d, 24'd0} | {n1_d, 16'd0} | {n2_d, 8'd0} | n3_d;
				server_port   <= {n4_d, 8'd0} | acc_d[15:0];
			end else begin
				category      <= q_tok.cmd_cat;
				address_found <= 1'b0;
				server_ip     <= '0;
				server_port   <= '0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/ftp_control_payload_classifier.sv
// Top level of the FTP control payload classifier.
`default_nettype none

// FTP control payload classifier. Payload bytes stream in one per transfer,
// offset zero first, with tlast on the final byte; tuser carries the
// direction (1 = server to client), sampled on the first byte only. One
// result transfer leaves per payload: category 1 login (USER), 2 download
// (RETR), 3 upload (STOR), 0 plain FTP. A server-to-client "227" reply with
// 'e' at offset 19 is parsed from offset 27 as six comma-separated decimal
// numbers closed by ')'; on success it is classed download, address_found is
// set and the server IP and port are reported, otherwise both read zero.
// Payloads too short to reach a checked byte do not match. Offsets beyond
// ftpc_pkg::MAX_PAYLOAD-1 saturate but bytes still feed the number parser.
// Rate: one byte per clock sustained while the queue is not full. The front
// classifies each byte against the header pattern and pushes a token into a
// four-entry queue; the back end pops one token per clock, while the queue
// holds one, into the number parser (a x10 accumulate) and registers the
// result, raising tvalid after the last byte's token leaves the queue. A
// stalled result output only holds the back end once it reaches the next
// payload's last byte, and the front keeps taking bytes until the queue fills.
module ftp_control_payload_classifier (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Byte stream in
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_axis_tuser,   // [0] direction
	input  wire logic        s_axis_tlast,   // last_byte
	// Classification out
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // [31:0] server_ip, [47:32] server_port
	output logic [2:0]       m_axis_tuser    // [1:0] category, [2] address_found
);

	ftpc_pkg::token_t push_tok;
	ftpc_pkg::token_t pop_tok;
	logic             push;
	logic             pop;
	logic             full;
	logic             not_empty;
	logic [1:0]       category;
	logic             address_found;
	logic [31:0]      server_ip;
	logic [15:0]      server_port;

	ftpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.data_byte (s_axis_tdata),
		.direction (s_axis_tuser[0]),
		.last_byte (s_axis_tlast),
		.q_full    (full),
		.q_push    (push),
		.q_tok     (push_tok)
	);

	ftpc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (push_tok),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_tok   (pop_tok)
	);

	ftpc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (not_empty),
		.q_tok         (pop_tok),
		.q_pop         (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.category      (category),
		.address_found (address_found),
		.server_ip     (server_ip),
		.server_port   (server_port)
	);

	assign m_axis_tdata = {server_port, server_ip};
	assign m_axis_tuser = {address_found, category};

endmodule

`default_nettype wire

FILE: test/ftp_control_payload_classifier_test.sv
// Self-checking testbench for the FTP control payload classifier.
`timescale 1ns / 1ps

module ftp_control_payload_classifier_test;

	// Generous bound on the whole run, in clock cycles.
	localparam int RUN_LIMIT = 600000;
	// Random traffic keeps going until both of these are reached.
	localparam int RANDOM_BYTES   = 200;
	localparam int RANDOM_RESULTS = 6;

	// Progress of the decimal address list inside a passive reply.
	typedef enum logic [1:0] {
		NUMS_READING,
		NUMS_CLOSED,
		NUMS_BROKEN
	} number_state_t;

	// One classification, as it should leave the block.
	typedef struct {
		ftpc_pkg::category_t cat;
		logic                found;
		logic [31:0]         ip;
		logic [15:0]         port;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic [0:0]  s_axis_tuser;   // [0] direction
	logic        s_axis_tlast;   // last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // [31:0] server_ip, [47:32] server_port
	logic [2:0]  m_axis_tuser;   // [1:0] category, [2] address_found

	ftp_control_payload_classifier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Classifier state mirrored by the predictor.
	logic [ftpc_pkg::POS_W-1:0] cur_pos;
	logic [7:0]                 lead;
	logic                       hdr_ok;
	logic                       to_client;
	logic [ftpc_pkg::IDX_W-1:0] fld_idx;
	logic [31:0]                fld [ftpc_pkg::NUM_FIELDS];
	number_state_t              num_state;

	verdict_t   expected_verdicts [$];
	logic [7:0] payload_q [$];
	string      reply_head = "227 Entering Passive Mode (";

	int  cycle_count    = 0;
	int  mismatch_count = 0;
	int  bytes_sent     = 0;
	int  payloads_sent  = 0;
	int  results_seen   = 0;
	int  passive_hits   = 0;
	int  hold_cycles    = 0;   // long receiver hold-off, counted down by the sink
	int  stall_left     = 0;
	bit  src_idle       = 1;
	bit  sink_idle      = 1;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("Mismatches found");
		$finish;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// Byte the header pattern demands at offset p for this lead byte, if any.
	function automatic bit checked_byte(input logic [7:0] lb,
			input logic [ftpc_pkg::POS_W-1:0] p, output logic [7:0] want);
		logic [7:0] w [1:3];
		bit reply;
		want  = 8'h00;
		reply = (lb == ftpc_pkg::CH_2);
		case (lb)
			ftpc_pkg::CH_U: w = '{ftpc_pkg::CH_S, ftpc_pkg::CH_E, ftpc_pkg::CH_R};
			ftpc_pkg::CH_R: w = '{ftpc_pkg::CH_E, ftpc_pkg::CH_T, ftpc_pkg::CH_R};
			ftpc_pkg::CH_S: w = '{ftpc_pkg::CH_T, ftpc_pkg::CH_O, ftpc_pkg::CH_R};
			ftpc_pkg::CH_2: w = '{ftpc_pkg::CH_2, ftpc_pkg::CH_7, 8'h00};
			default: return 1'b0;
		endcase
		if ((p >= 1 && p <= 2) || (p == 3 && !reply)) begin
			want = w[p];
			return 1'b1;
		end
		if (reply && p == ftpc_pkg::REPLY_MARK_POS) begin
			want = ftpc_pkg::CH_LOW_E;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Decimal list parser: digits accumulate mod 2^32, commas step fields,
	// ')' in the sixth field closes, anything else breaks the list.
	task automatic parse_number_byte(input logic [7:0] b);
		if (num_state != NUMS_READING || fld_idx >= ftpc_pkg::NUM_FIELDS)
			return;
		if (b >= ftpc_pkg::CH_0 && b <= ftpc_pkg::CH_9) begin
			fld[fld_idx] = fld[fld_idx] * 10 + 32'(b - ftpc_pkg::CH_0);
		end else if (b == ftpc_pkg::CH_COMMA) begin
			fld_idx = fld_idx + 1'b1;
			if (fld_idx >= ftpc_pkg::NUM_FIELDS)
				num_state = NUMS_BROKEN;
		end else if (b == ftpc_pkg::CH_RPAREN && fld_idx == ftpc_pkg::NUM_FIELDS - 1) begin
			num_state = NUMS_CLOSED;
		end else begin
			num_state = NUMS_BROKEN;
		end
	endtask

	// Advance the mirrored state by one accepted byte; queue the verdict on tlast.
	task automatic classify_byte(input logic [7:0] b, input logic dir, input logic is_last);
		logic [7:0] want;
		verdict_t v;
		if (cur_pos == '0) begin
			lead      = b;
			to_client = dir;
			hdr_ok    = 1'b1;
			fld_idx   = '0;
			foreach (fld[i])
				fld[i] = '0;
			num_state = NUMS_READING;
		end else if (checked_byte(lead, cur_pos, want) && b != want) begin
			hdr_ok = 1'b0;
		end
		if (cur_pos >= ftpc_pkg::NUM_START)
			parse_number_byte(b);
		if (!is_last) begin
			if (cur_pos != ftpc_pkg::POS_MAX)
				cur_pos = cur_pos + 1'b1;
			return;
		end
		v = '{cat: ftpc_pkg::CAT_PLAIN, found: 1'b0, ip: '0, port: '0};
		case (lead)
			ftpc_pkg::CH_U: if (hdr_ok && cur_pos >= 3) v.cat = ftpc_pkg::CAT_LOGIN;
			ftpc_pkg::CH_R: if (hdr_ok && cur_pos >= 3) v.cat = ftpc_pkg::CAT_DOWNLOAD;
			ftpc_pkg::CH_S: if (hdr_ok && cur_pos >= 3) v.cat = ftpc_pkg::CAT_UPLOAD;
			ftpc_pkg::CH_2: begin
				if (to_client && hdr_ok && cur_pos >= ftpc_pkg::REPLY_MARK_POS &&
						num_state == NUMS_CLOSED) begin
					v.cat   = ftpc_pkg::CAT_DOWNLOAD;
					v.found = 1'b1;
					v.ip    = (fld[0] << 24) | (fld[1] << 16) | (fld[2] << 8) | fld[3];
					v.port  = 16'((fld[4] << 8) | fld[5]);
				end
			end
			default: ;
		endcase
		expected_verdicts.push_back(v);
		cur_pos = '0;
	endtask

	// Offer one byte, after an optional gap, and wait for its transfer.
	task automatic send_byte(input logic [7:0] b, input logic dir, input logic is_last);
		int gap;
		gap = src_idle ? idle_length() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= dir;
		s_axis_tlast  <= is_last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		classify_byte(b, dir, is_last);
		bytes_sent++;
	endtask

	// Later bytes carry a random direction: only the first one counts.
	task automatic send_payload(input logic dir);
		for (int i = 0; i < payload_q.size(); i++)
			send_byte(payload_q[i], (i == 0) ? dir : 1'($urandom),
				i == payload_q.size() - 1);
		payload_q.delete();
		payloads_sent++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			payload_q.push_back(s[i]);
	endtask

	task automatic push_digits(input int n);
		repeat (n) payload_q.push_back(ftpc_pkg::CH_0 + 8'($urandom_range(0, 9)));
	endtask

	task automatic send_text(input string s, input logic dir);
		payload_q.delete();
		push_text(s);
		send_payload(dir);
	endtask

	// Stop offering and wait until every queued verdict has been checked.
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// Octets mostly, sometimes values that wrap, empty fields or long digit runs.
	task automatic push_rand_number();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			push_text($sformatf("%0d", $urandom_range(0, 255)));
		else if (r < 85)
			push_text($sformatf("%0d", $urandom));
		else if (r >= 92)
			push_digits($urandom_range(11, 20));
	endtask

	// Passive reply with `fields` numbers, optionally closed, random trailer.
	task automatic build_reply(input int fields, input bit closed);
		payload_q.delete();
		push_text(reply_head);
		// unchecked header bytes may hold anything
		if ($urandom_range(0, 1))
			for (int p = 3; p < ftpc_pkg::NUM_START; p++)
				if (p != ftpc_pkg::REPLY_MARK_POS)
					payload_q[p] = 8'($urandom);
		for (int i = 0; i < fields; i++) begin
			if (i != 0)
				payload_q.push_back(ftpc_pkg::CH_COMMA);
			push_rand_number();
		end
		if (closed)
			payload_q.push_back(ftpc_pkg::CH_RPAREN);
		repeat ($urandom_range(0, 4)) payload_q.push_back(8'($urandom));
	endtask

	task automatic check_field(input string fname, input logic [31:0] exp,
			input logic [31:0] got);
		if (exp !== got) begin
			$display("%0t: ERROR %s expected %h, got %h", $time, fname, exp, got);
			mismatch_count++;
		end
	endtask

	// Result checker and receiver: stalls, long hold-offs, otherwise ready.
	always @(posedge clk) begin : result_sink
		verdict_t v;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: ERROR unexpected result, category %0d found %0d ip %h port %h",
					$time, m_axis_tuser[1:0], m_axis_tuser[2], m_axis_tdata[31:0],
					m_axis_tdata[47:32]);
				mismatch_count++;
			end else begin
				v = expected_verdicts.pop_front();
				check_field("category", 32'(v.cat), 32'(m_axis_tuser[1:0]));
				check_field("address_found", 32'(v.found), 32'(m_axis_tuser[2]));
				check_field("server_ip", v.ip, m_axis_tdata[31:0]);
				check_field("server_port", 32'(v.port), 32'(m_axis_tdata[47:32]));
				results_seen++;
				if (v.found)
					passive_hits++;
			end
		end
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles--;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if (sink_idle)
				stall_left = idle_length();
		end
	end

	// Command words, exact and with tails, plus near misses.
	task automatic test_command_words();
		send_text("USER anonymous\r\n", 1'b0);
		send_text("RETR file.bin\r\n", 1'b0);
		send_text("STOR upload.txt\r\n", 1'b1);
		send_text("USER", 1'b0);
		send_text("user x", 1'b0);
		send_text("USEX", 1'b0);
		send_text("RETS", 1'b0);
		send_text("STOP", 1'b0);
		wait_for_results();
	endtask

	// Payloads that end at or before the last checked byte.
	task automatic test_short_payloads();
		send_text("U", 1'b0);
		send_text("US", 1'b1);
		send_text("USE", 1'b0);
		send_text("RET", 1'b0);
		send_text("STO", 1'b0);
		send_text("22", 1'b1);
		send_text("227", 1'b1);
		send_text("227 Entering Passiv", 1'b1);   // ends just before the 'e'
		send_text("227 Entering Passive", 1'b1);  // ends on the 'e'
		wait_for_results();
	endtask

	task automatic test_passive_replies();
		send_text({reply_head, "192,168,1,2,19,137).\r\n"}, 1'b1);
		send_text({reply_head, "255,255,255,255,255,255)"}, 1'b1);
		send_text({reply_head, "0,0,0,0,0,0)"}, 1'b1);
		send_text({reply_head, ",,,,,)"}, 1'b1);
		// large values, some of which wrap the 32-bit accumulator
		send_text({reply_head, "4294967295,4294967296,99999999999,1,65535,65536)"}, 1'b1);
		// same text travelling client to server is plain
		send_text({reply_head, "10,0,0,1,4,1)"}, 1'b0);
		wait_for_results();
	endtask

	task automatic test_malformed_replies();
		send_text({reply_head, "1,2,3,4,5,6,7)"}, 1'b1);      // seventh field
		send_text({reply_head, "1,2,3)"}, 1'b1);              // closed too early
		send_text({reply_head, "1,2,x3,4,5,6)"}, 1'b1);       // stray letter
		send_text({reply_head, "1,2,3,4,5,6"}, 1'b1);         // never closed
		send_text({reply_head, "1,2,3,4,5,6)zz,9)"}, 1'b1);   // trailer ignored
		send_text("227 Entering PassivE Mode (1,2,3,4,5,6)", 1'b1);
		send_text("237 Entering Passive Mode (1,2,3,4,5,6)", 1'b1);
		wait_for_results();
	endtask

	// Receiver holds off while bytes keep coming, so the block backs up.
	task automatic test_output_backpressure();
		src_idle    = 0;
		hold_cycles = 300;
		repeat (6) begin
			send_text("USER", 1'b0);
			send_text("RETR", 1'b1);
			send_text({reply_head, "1,2,3,4,5,6)"}, 1'b1);
		end
		wait_for_results();
		src_idle = 1;
	endtask

	task automatic test_random_traffic();
		int r, k, p, len;
		int first_byte, first_result;
		first_byte   = bytes_sent;
		first_result = results_seen;
		while (bytes_sent - first_byte < RANDOM_BYTES ||
				results_seen - first_result < RANDOM_RESULTS) begin
			if ($urandom_range(0, 9) == 0)
				src_idle = !src_idle;
			if ($urandom_range(0, 9) == 0)
				sink_idle = !sink_idle;
			r = $urandom_range(0, 99);
			if (r < 40) begin
				build_reply(ftpc_pkg::NUM_FIELDS, 1'b1);
				send_payload(1'b1);
			end else if (r < 55) begin
				k = $urandom_range(0, 5);
				build_reply((k == 4) ? ftpc_pkg::NUM_FIELDS + 1 : ftpc_pkg::NUM_FIELDS,
					k != 5);
				case (k)
					1: begin
						p = $urandom_range(0, 2);
						p = (p == 0) ? 1 : (p == 1) ? 2 : ftpc_pkg::REPLY_MARK_POS;
						payload_q[p] ^= 8'(1 << $urandom_range(0, 7));
					end
					2: begin
						p = $urandom_range(ftpc_pkg::NUM_START, payload_q.size() - 1);
						payload_q[p] = 8'($urandom);
					end
					3: begin
						len = $urandom_range(1, payload_q.size());
						while (payload_q.size() > len)
							void'(payload_q.pop_back());
					end
					default: ;
				endcase
				send_payload(k != 0);
			end else if (r < 75) begin
				payload_q.delete();
				case ($urandom_range(0, 2))
					0: push_text("USER");
					1: push_text("RETR");
					default: push_text("STOR");
				endcase
				repeat ($urandom_range(0, 12)) payload_q.push_back(8'($urandom));
				k = $urandom_range(0, 99);
				if (k < 25) begin
					payload_q[$urandom_range(1, 3)] ^= 8'(1 << $urandom_range(0, 7));
				end else if (k < 40) begin
					len = $urandom_range(1, 3);
					while (payload_q.size() > len)
						void'(payload_q.pop_back());
				end
				send_payload(1'($urandom));
			end else begin
				payload_q.delete();
				if (r < 90) begin
					repeat ($urandom_range(1, 40)) payload_q.push_back(8'($urandom));
				end else begin
					case ($urandom_range(0, 3))
						0: payload_q.push_back(ftpc_pkg::CH_U);
						1: payload_q.push_back(ftpc_pkg::CH_R);
						2: payload_q.push_back(ftpc_pkg::CH_S);
						default: payload_q.push_back(ftpc_pkg::CH_2);
					endcase
					repeat ($urandom_range(0, 24)) payload_q.push_back(8'($urandom));
				end
				send_payload(1'($urandom));
			end
		end
		wait_for_results();
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		s_axis_tlast  <= 1'b0;
		m_axis_tready <= 1'b0;
		cur_pos   = '0;
		lead      = '0;
		hdr_ok    = 1'b1;
		to_client = 1'b0;
		fld_idx   = '0;
		foreach (fld[i])
			fld[i] = '0;
		num_state = NUMS_READING;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_command_words();
		test_short_payloads();
		test_passive_replies();
		test_malformed_replies();
		test_output_backpressure();
		test_random_traffic();

		repeat (10) @(posedge clk);
		if (expected_verdicts.size() != 0) begin
			$display("%0t: ERROR %0d results never arrived", $time, expected_verdicts.size());
			mismatch_count += expected_verdicts.size();
		end
		$display("Run covered %0d payloads, %0d bytes, %0d results checked,",
			payloads_sent, bytes_sent, results_seen);
		$display("%0d of them decoded passive replies with a server address.", passive_hits);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
